@@ rtl/core/sliding_window_max_defines.svh @@
// assertion macros shared by the sliding window maximum rtl
`ifndef SLIDING_WINDOW_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MAX_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define SWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// property whose consequent is checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define SWM_ASSERT(name, prop, msg)
`define SWM_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

@@ rtl/core/swm_pkg.sv @@
// shared types and constants of the sliding window maximum filter
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int             CFG_W        = 7;
  localparam logic [CFG_W-1:0] WS_RESET   = 7'd3;
  localparam int             APB_ADDR_W   = 3;
  localparam int             APB_DATA_W   = 32;
  localparam logic           REG_WS       = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BACK,
    ST_PUSH
  } swm_state_t;

  typedef struct packed {
    logic load;
    logic fr_pop;
    logic fr_keep;
    logic bk_pop;
    logic push;
  } swm_cmd_t;

  typedef struct packed {
    logic empty_in;
    logic stale;
    logic single;
    logic smaller;
    logic out_block;
  } swm_stat_t;

endpackage

@@ rtl/core/swm_ram.sv @@
// generic single write port ram with registered read
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/swm_ctrl.sv @@
// controller state machine sequencing the deque pops and the push
module swm_ctrl import swm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  swm_stat_t stat,
  output swm_cmd_t  cmd
);

  swm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.empty_in ? ST_PUSH : ST_FRONT;
        end
      end
      ST_FRONT: begin
        if (stat.stale) begin
          cmd.fr_pop = 1'b1;
          state_nxt  = stat.single ? ST_PUSH : ST_FRONT;
        end else begin
          cmd.fr_keep = 1'b1;
          state_nxt   = ST_BACK;
        end
      end
      ST_BACK: begin
        if (stat.smaller) begin
          cmd.bk_pop = 1'b1;
          state_nxt  = stat.single ? ST_PUSH : ST_BACK;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!stat.out_block) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/swm_dp.sv @@
// datapath: deque memory, pointers, counters and output register
`include "sliding_window_max_defines.svh"
module swm_dp import swm_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swm_cmd_t                cmd,
  output swm_stat_t               stat,
  input  logic [CFG_W-1:0]        ws,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    in_start,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [SAMPLE_WIDTH-1:0] out_data
);

  localparam int ADDRW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNTW  = $clog2(WINDOW_MAX + 1);
  localparam int POSW  = $clog2(2 * WINDOW_MAX);
  localparam int AGEW  = POSW + 1;
  localparam int SUMW  = ((ADDRW > CNTW) ? ADDRW : CNTW) + 1;
  localparam int WORDW = POSW + SAMPLE_WIDTH;

  logic [ADDRW-1:0]        head_r, head_nxt;
  logic [CNTW-1:0]         count_r, count_nxt;
  logic [POSW-1:0]         spos_r, spos_nxt;
  logic [CNTW-1:0]         seen_r, seen_nxt;
  logic [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic [SAMPLE_WIDTH-1:0] front_val_r, front_val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [ADDRW-1:0]        rd_addr;
  logic [ADDRW-1:0]        wr_addr;
  logic [WORDW-1:0]        rd_word;
  logic [SAMPLE_WIDTH-1:0] rd_val;
  logic [POSW-1:0]         rd_pos;
  logic [AGEW-1:0]         age;
  logic [CNTW-1:0]         k_eff;
  logic [CNTW-1:0]         seen_inc;
  logic                    emit;

  function automatic logic [ADDRW-1:0] slot_of(input logic [ADDRW-1:0] base,
                                               input logic [CNTW-1:0]  off);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(off);
    if (sum >= SUMW'(WINDOW_MAX)) begin
      sum = sum - SUMW'(WINDOW_MAX);
    end
    return ADDRW'(sum);
  endfunction

  swm_ram #(
    .WIDTH (WORDW),
    .DEPTH (WINDOW_MAX)
  ) u_deque (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_addr),
    .wdata ({spos_r, smp_r}),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  assign rd_val  = rd_word[SAMPLE_WIDTH-1:0];
  assign rd_pos  = rd_word[SAMPLE_WIDTH +: POSW];
  assign wr_addr = slot_of(head_r, count_r);

  // window length, clamped to 1..WINDOW_MAX
  always_comb begin
    if (ws == '0) begin
      k_eff = CNTW'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      k_eff = CNTW'(WINDOW_MAX);
    end else begin
      k_eff = CNTW'(ws);
    end
  end

  // distance of the entry just read from the current sample position
  always_comb begin
    if (spos_r >= rd_pos) begin
      age = AGEW'(spos_r) - AGEW'(rd_pos);
    end else begin
      age = AGEW'(spos_r) + AGEW'(2 * WINDOW_MAX) - AGEW'(rd_pos);
    end
  end

  assign seen_inc = (int'(seen_r) == WINDOW_MAX) ? seen_r : seen_r + CNTW'(1);
  assign emit     = int'(seen_inc) >= int'(k_eff);

  always_comb begin
    stat.empty_in  = in_start || (count_r == '0);
    stat.stale     = int'(age) >= int'(k_eff);
    stat.single    = (count_r == CNTW'(1));
    stat.smaller   = $signed(rd_val) < $signed(smp_r);
    stat.out_block = emit && out_valid_r && !out_ready;
  end

  // next read is issued in the same cycle as the decision on the current one
  always_comb begin
    rd_addr = head_r;
    if (cmd.load) begin
      rd_addr = in_start ? '0 : head_r;
    end else if (cmd.fr_pop) begin
      rd_addr = slot_of(head_r, CNTW'(1));
    end else if (cmd.fr_keep) begin
      rd_addr = slot_of(head_r, count_r - CNTW'(1));
    end else if (cmd.bk_pop) begin
      rd_addr = slot_of(head_r, count_r - CNTW'(2));
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    spos_nxt      = spos_r;
    seen_nxt      = seen_r;
    smp_nxt       = smp_r;
    front_val_nxt = front_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.load) begin
      smp_nxt = in_sample;
      if (in_start) begin
        head_nxt  = '0;
        count_nxt = '0;
        spos_nxt  = '0;
        seen_nxt  = '0;
      end
    end
    if (cmd.fr_pop) begin
      head_nxt  = slot_of(head_r, CNTW'(1));
      count_nxt = count_r - CNTW'(1);
    end
    if (cmd.fr_keep) begin
      front_val_nxt = rd_val;
    end
    if (cmd.bk_pop) begin
      count_nxt = count_r - CNTW'(1);
    end
    if (cmd.push) begin
      count_nxt = count_r + CNTW'(1);
      spos_nxt  = (spos_r == POSW'(2 * WINDOW_MAX - 1)) ? '0 : spos_r + POSW'(1);
      seen_nxt  = seen_inc;
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = (count_r == '0) ? smp_r : front_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      spos_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      spos_r      <= spos_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r       <= smp_nxt;
    front_val_r <= front_val_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SWM_ASSERT(a_push_room, cmd.push |-> int'(count_r) < WINDOW_MAX, "push into a full deque")
  `SWM_ASSERT(a_pop_live, (cmd.fr_pop || cmd.bk_pop) |-> count_r != '0, "pop from an empty deque")
  `SWM_ASSERT_NEXT(a_max_bound, cmd.push && emit, out_valid_r && ($signed(out_data_r) >= $signed($past(smp_r))), "window max below newest sample")
  `SWM_ASSERT(a_seen_sat, int'(seen_r) <= WINDOW_MAX, "sample count past saturation")

endmodule

@@ rtl/core/sliding_window_max.sv @@
// sliding window maximum filter top level: config register, controller, datapath
// sequencing: a sample is accepted in the idle state, checked against the deque front and back
//   (one deque entry per check), then pushed, which loads the output register once the window
//   has filled; output stalls hold off the push. A new sample is accepted only after that push,
//   and each sample is pushed once and dropped at most once
// reset: synchronous active low, empties the deque, window_size back to 3, ram not cleared
module sliding_window_max import swm_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // sample, zero padded above
  input  logic                  in_tuser,   // start_req
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // window_max, zero padded above
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [CFG_W-1:0]        ws_r, ws_nxt;
  logic                    cfg_wr;
  swm_cmd_t                cmd;
  swm_stat_t               stat;
  logic [SAMPLE_WIDTH-1:0] max_data;

  // config register, word index taken from address bit 2
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    ws_nxt = ws_r;
    if (cfg_wr && (cfg_paddr[2] == REG_WS)) begin
      ws_nxt = cfg_pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else begin
      ws_r <= ws_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_WS) ? APB_DATA_W'(ws_r) : '0;

  // controller walks front drops, back drops, then the push and result
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath holds the deque ram, pointers and the output register
  swm_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .ws        (ws_r),
    .in_sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_start  (in_tuser),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (max_data)
  );

  assign out_tdata = DATA_W'(max_data);

endmodule
